[rtl/priority_token_budget_evictor_defines.svh]
// ----------------------------------------------------------------------------
// priority token budget evictor: assertion macros
// shared property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TOKEN_BUDGET_EVICTOR_DEFINES_SVH
`define PRIORITY_TOKEN_BUDGET_EVICTOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PTBE_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PTBE_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

[rtl/ptbe_pkg.sv]
// ----------------------------------------------------------------------------
// ptbe_pkg
// shared codes and types of the priority token budget evictor
// ----------------------------------------------------------------------------
`default_nettype none

package ptbe_pkg;

  localparam int unsigned TOK_W      = 16;
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned BPT_W      = 8;
  localparam int unsigned DIVIDEND_W = 17;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPMODE = 2'd3;

  typedef struct packed {
    logic [1:0]       prio;
    logic [TOK_W-1:0] tokens;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/ptbe_ram.sv]
// ----------------------------------------------------------------------------
// ptbe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ptbe_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/ptbe_div.sv]
// ----------------------------------------------------------------------------
// ptbe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ptbe_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ptbe_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  wire logic [ptbe_pkg::BPT_W-1:0]          divisor_i,
  output logic                                     done_o,
  output logic      [ptbe_pkg::DIVIDEND_W-1:0]     quotient_o
);

  localparam int unsigned DW  = ptbe_pkg::DIVIDEND_W;
  localparam int unsigned VW  = ptbe_pkg::BPT_W;
  localparam int unsigned CNW = $clog2(DW + 1);

  logic [DW-1:0]  dvd_q, dvd_d;
  logic [VW-1:0]  dvs_q, dvs_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [VW:0]    rem_sh;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, dvd_q[DW-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift in at the bottom as dividend bits leave the top
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = VW'(rem_sh - {1'b0, dvs_q});
        dvd_d = {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[VW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

[rtl/priority_token_budget_evictor.sv]
// ----------------------------------------------------------------------------
// priority_token_budget_evictor
// age-ordered entry store under a token budget with tiered eviction
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start_i / busy_o       opcode_i, priority_level_i, byte_length_i
//  result    valid_o (one cycle)    status_o ... is_full_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  clear goes straight to the result. add runs the token divide (skipped at
//  divisor 0), the budget check, a select step for each of the five eviction
//  passes plus a read-and-repack sweep of the held entries for each pass that
//  runs, then the append; forced and full-store passes never both run.
//  results show for one cycle with busy_o low; the receiver cannot stall.
//  reset empties the store at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_token_budget_evictor #(
  parameter int unsigned MAX_ENTRIES  = 64,
  parameter int unsigned BUDGET_WIDTH = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 opcode_i,
  input  wire logic [1:0]                           priority_level_i,
  input  wire logic [ptbe_pkg::BYTES_W-1:0]         byte_length_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ptbe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [ptbe_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                      valid_o,
  output logic      [1:0]                           status_o,
  output logic      [ptbe_pkg::TOK_W-1:0]           message_tokens_o,
  output logic      [$clog2(MAX_ENTRIES+1)-1:0]     evicted_entries_o,
  output logic      [BUDGET_WIDTH-1:0]              evicted_tokens_o,
  output logic      [BUDGET_WIDTH-1:0]              store_tokens_o,
  output logic      [$clog2(MAX_ENTRIES+1)-1:0]     entry_count_o,
  output logic      [BUDGET_WIDTH-1:0]              remaining_tokens_o,
  output logic                                      is_full_o
);

  localparam int unsigned BW  = BUDGET_WIDTH;
  localparam int unsigned TW  = ptbe_pkg::TOK_W;
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned SW  = ((BW > TW) ? BW : TW) + 1;
  localparam int unsigned EW  = ptbe_pkg::ENTRY_W;
  localparam int unsigned DW  = ptbe_pkg::DIVIDEND_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_PSEL = 3'd3;
  localparam logic [2:0] S_PASS = 3'd4;
  localparam logic [2:0] S_APP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [2:0] P_TIER_LOW  = 3'd0;
  localparam logic [2:0] P_TIER_NORM = 3'd1;
  localparam logic [2:0] P_TIER_HIGH = 3'd2;
  localparam logic [2:0] P_FORCE     = 3'd3;
  localparam logic [2:0] P_FULL      = 3'd4;

  // configuration
  logic [BW-1:0]                budget_q;
  logic [ptbe_pkg::BPT_W-1:0]   bpt_q;
  logic                         auto_q;
  logic                         cmode_q;

  // control
  logic [2:0]    state_q, state_d;
  logic [2:0]    pass_q, pass_d;
  logic [CW-1:0] held_cnt_q, held_cnt_d;
  logic [BW-1:0] held_tok_q, held_tok_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] num_q, num_d;
  logic          rv_q, rv_d;
  logic          first_q, first_d;
  logic          valid_q, valid_d;

  // per request payload
  logic [1:0]    prio_q, prio_d;
  logic [TW-1:0] tok_q, tok_d;
  logic [1:0]    status_q, status_d;
  logic [CW-1:0] ev_ent_q, ev_ent_d;
  logic [BW-1:0] ev_tok_q, ev_tok_d;
  logic [BW-1:0] rem_q, rem_d;
  logic          full_q, full_d;

  // ram and divider
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  ptbe_pkg::entry_t    ram_wdata, ram_rdata;
  logic [EW-1:0]       ram_rdata_raw;
  logic                div_start, div_done;
  logic [DW-1:0]       div_quot;
  logic [DW-1:0]       dividend;

  logic ovf;
  logic gate;
  logic pass_en;
  logic drop;

  assign ovf  = (SW'(held_tok_q) + SW'(tok_q)) > SW'(budget_q);
  assign gate = auto_q & cmode_q;
  assign dividend = DW'(byte_length_i) + DW'(bpt_q) - DW'(1);
  assign ram_rdata = ptbe_pkg::entry_t'(ram_rdata_raw);

  always_comb begin
    unique case (pass_q)
      P_TIER_LOW, P_TIER_NORM, P_TIER_HIGH: pass_en = ovf & gate & (held_cnt_q != '0);
      P_FORCE:                              pass_en = ovf & (held_cnt_q != '0);
      P_FULL:                               pass_en = (held_cnt_q == CW'(MAX_ENTRIES));
      default:                              pass_en = 1'b0;
    endcase
  end

  always_comb begin
    unique case (pass_q)
      P_TIER_LOW, P_TIER_NORM, P_TIER_HIGH: drop = ovf & (ram_rdata.prio == pass_q[1:0]);
      P_FORCE:                              drop = ovf;
      P_FULL:                               drop = first_q;
      default:                              drop = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    held_cnt_d = held_cnt_q;
    held_tok_d = held_tok_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    num_d      = num_q;
    rv_d       = 1'b0;
    first_d    = 1'b0;
    valid_d    = 1'b0;
    prio_d     = prio_q;
    tok_d      = tok_q;
    status_d   = status_q;
    ev_ent_d   = ev_ent_q;
    ev_tok_d   = ev_tok_q;
    rem_d      = rem_q;
    full_d     = full_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_q[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = rd_q[AW-1:0];
    div_start  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          prio_d   = priority_level_i;
          ev_ent_d = '0;
          ev_tok_d = '0;
          tok_d    = '0;
          pass_d   = P_TIER_LOW;
          if (opcode_i == ptbe_pkg::OP_CLEAR) begin
            ev_ent_d   = held_cnt_q;
            ev_tok_d   = held_tok_q;
            held_cnt_d = '0;
            held_tok_d = '0;
            status_d   = ptbe_pkg::ST_CLEARED;
            state_d    = S_FIN;
          end else if (bpt_q == '0) begin
            state_d = S_CHK;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          tok_d   = div_quot[TW-1:0];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (SW'(tok_q) > SW'(budget_q)) begin
          status_d = ptbe_pkg::ST_REFUSED;
          state_d  = S_FIN;
        end else begin
          state_d = S_PSEL;
        end
      end
      S_PSEL: begin
        if (pass_en) begin
          rd_d    = '0;
          wr_d    = '0;
          num_d   = held_cnt_q;
          state_d = S_PASS;
        end else if (pass_q == P_FULL) begin
          state_d = S_APP;
        end else begin
          pass_d = pass_q + 3'd1;
        end
      end
      S_PASS: begin
        if (rd_q != num_q) begin
          ram_re  = 1'b1;
          rd_d    = rd_q + CW'(1);
          rv_d    = 1'b1;
          first_d = (rd_q == '0);
        end
        // survivors are written back packed toward slot 0, order kept
        if (rv_q) begin
          if (drop) begin
            held_tok_d = held_tok_q - BW'(ram_rdata.tokens);
            ev_ent_d   = ev_ent_q + CW'(1);
            ev_tok_d   = ev_tok_q + BW'(ram_rdata.tokens);
          end else begin
            ram_we = 1'b1;
            wr_d   = wr_q + CW'(1);
          end
        end
        if (rd_q == num_q && !rv_q) begin
          held_cnt_d = wr_q;
          if (pass_q == P_FULL) begin
            state_d = S_APP;
          end else begin
            pass_d  = pass_q + 3'd1;
            state_d = S_PSEL;
          end
        end
      end
      S_APP: begin
        ram_we           = 1'b1;
        ram_waddr        = held_cnt_q[AW-1:0];
        ram_wdata.prio   = prio_q;
        ram_wdata.tokens = tok_q;
        held_cnt_d       = held_cnt_q + CW'(1);
        held_tok_d       = held_tok_q + BW'(tok_q);
        status_d         = ptbe_pkg::ST_ADDED;
        state_d          = S_FIN;
      end
      S_FIN: begin
        rem_d   = (budget_q > held_tok_q) ? (budget_q - held_tok_q) : '0;
        full_d  = (held_tok_q >= budget_q);
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pass_q     <= P_TIER_LOW;
      held_cnt_q <= '0;
      held_tok_q <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      num_q      <= '0;
      rv_q       <= 1'b0;
      first_q    <= 1'b0;
      valid_q    <= 1'b0;
      budget_q   <= BW'(32'd4096);
      bpt_q      <= 8'd4;
      auto_q     <= 1'b1;
      cmode_q    <= 1'b1;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      held_cnt_q <= held_cnt_d;
      held_tok_q <= held_tok_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      num_q      <= num_d;
      rv_q       <= rv_d;
      first_q    <= first_d;
      valid_q    <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptbe_pkg::REG_BUDGET:   budget_q <= BW'(cfg_wdata_i);
          ptbe_pkg::REG_BPT:      bpt_q    <= cfg_wdata_i[ptbe_pkg::BPT_W-1:0];
          ptbe_pkg::REG_AUTO:     auto_q   <= cfg_wdata_i[0];
          ptbe_pkg::REG_COMPMODE: cmode_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q   <= prio_d;
    tok_q    <= tok_d;
    status_q <= status_d;
    ev_ent_q <= ev_ent_d;
    ev_tok_q <= ev_tok_d;
    rem_q    <= rem_d;
    full_q   <= full_d;
  end

  ptbe_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  ptbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (bpt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign busy_o             = (state_q != S_IDLE);
  assign valid_o            = valid_q;
  assign status_o           = status_q;
  assign message_tokens_o   = tok_q;
  assign evicted_entries_o  = ev_ent_q;
  assign evicted_tokens_o   = ev_tok_q;
  assign store_tokens_o     = held_tok_q;
  assign entry_count_o      = held_cnt_q;
  assign remaining_tokens_o = rem_q;
  assign is_full_o          = full_q;

endmodule

`default_nettype wire

[rtl/ptbe_checker.sv]
// ----------------------------------------------------------------------------
// ptbe_checker
// port-level checks of the priority token budget evictor
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_token_budget_evictor_defines.svh"

module ptbe_checker #(
  parameter int unsigned MAX_ENTRIES  = 64,
  parameter int unsigned BUDGET_WIDTH = 20
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              valid_o,
  input wire logic [1:0]                        status_o,
  input wire logic [ptbe_pkg::TOK_W-1:0]        message_tokens_o,
  input wire logic [BUDGET_WIDTH-1:0]           store_tokens_o,
  input wire logic [$clog2(MAX_ENTRIES+1)-1:0]  entry_count_o
);

  `PTBE_ASSERT_NEXT(a_req_busy, start_i && !busy_o, busy_o, "request not taken up")
  `PTBE_ASSERT_NOW(a_res_idle, valid_o, !busy_o, "result while busy")
  `PTBE_ASSERT_NEXT(a_res_pulse, valid_o, !valid_o, "result held longer than one cycle")
  `PTBE_ASSERT_NOW(a_add_nonempty, valid_o && status_o == ptbe_pkg::ST_ADDED,
                   entry_count_o != '0, "add left store empty")
  `PTBE_ASSERT_NOW(a_clear_empty, valid_o && status_o == ptbe_pkg::ST_CLEARED,
                   store_tokens_o == '0 && entry_count_o == '0 && message_tokens_o == '0,
                   "clear left data")

endmodule

bind priority_token_budget_evictor ptbe_checker #(
  .MAX_ENTRIES  (MAX_ENTRIES),
  .BUDGET_WIDTH (BUDGET_WIDTH)
) u_ptbe_checker (.*);

`default_nettype wire

[dv/tb_priority_token_budget_evictor.sv]
// ----------------------------------------------------------------------------
// tb_priority_token_budget_evictor
// self-checking bench: drives add and clear requests under several budget,
// divisor and compression settings, predicts every result with a local model
// of the age-ordered store and compares each result field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_priority_token_budget_evictor;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbe_pkg::*;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned BW       = 20;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned BMASK    = (1 << BW) - 1;
  localparam int unsigned TAIL_CYC = 5 * (SLOTS + 3) + 40;
  localparam int unsigned LIMIT    = 2000000;

  typedef struct {
    logic [1:0]       status;
    logic [TOK_W-1:0] tokens;
    logic [CNT_W-1:0] ev_entries;
    logic [BW-1:0]    ev_tokens;
    logic [BW-1:0]    total;
    logic [CNT_W-1:0] count;
    logic [BW-1:0]    remaining;
    logic             full;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic opcode_i = OP_ADD;
  logic [1:0] priority_level_i = 2'd0;
  logic [BYTES_W-1:0] byte_length_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_BUDGET;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic busy_o, valid_o, is_full_o;
  logic [1:0] status_o;
  logic [TOK_W-1:0] message_tokens_o;
  logic [CNT_W-1:0] evicted_entries_o, entry_count_o;
  logic [BW-1:0] evicted_tokens_o, store_tokens_o, remaining_tokens_o;

  priority_token_budget_evictor #(.MAX_ENTRIES(SLOTS), .BUDGET_WIDTH(BW)) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .priority_level_i, .byte_length_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .valid_o, .status_o, .message_tokens_o,
    .evicted_entries_o, .evicted_tokens_o, .store_tokens_o, .entry_count_o,
    .remaining_tokens_o, .is_full_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model of the store
  entry_t      store_q[$];
  int unsigned held_tok;
  int unsigned budget_r = 4096;
  int unsigned bpt_r = 4;
  bit          auto_r = 1'b1;
  bit          mode_r = 1'b1;
  int unsigned step_n, step_tok;

  outcome_t    pending_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_priority_token_budget_evictor: done, errors");
      $finish;
    end
  end

  function automatic bit over_budget(int unsigned tok);
    return longint'(held_tok) + tok > longint'(budget_r);
  endfunction

  function automatic void evict_slot(int unsigned idx);
    held_tok = (held_tok - store_q[idx].tokens) & BMASK;
    step_n++;
    step_tok += store_q[idx].tokens;
    store_q.delete(idx);
  endfunction

  function automatic void tier_sweep(logic [1:0] prio, int unsigned tok);
    int unsigned i;
    i = 0;
    while (i < store_q.size() && over_budget(tok)) begin
      if (store_q[i].prio == prio) evict_slot(i);
      else i++;
    end
  endfunction

  function automatic outcome_t predict_store(logic op, logic [1:0] prio,
                                             logic [BYTES_W-1:0] len);
    outcome_t    o;
    int unsigned tok;
    entry_t      e;
    tok = 0;
    step_n = 0;
    step_tok = 0;
    if (op == OP_CLEAR) begin
      step_n = store_q.size();
      step_tok = held_tok;
      store_q.delete();
      held_tok = 0;
      o.status = ST_CLEARED;
    end else begin
      if (bpt_r != 0) tok = (int'(len) + bpt_r - 1) / bpt_r;
      if (tok > budget_r) begin
        o.status = ST_REFUSED;
      end else begin
        if (over_budget(tok)) begin
          if (auto_r && mode_r) begin
            tier_sweep(2'd0, tok);
            tier_sweep(2'd1, tok);
            tier_sweep(2'd2, tok);
          end
          while (store_q.size() > 0 && over_budget(tok)) evict_slot(0);
        end
        if (store_q.size() >= SLOTS) evict_slot(0);
        e.prio = prio;
        e.tokens = tok[TOK_W-1:0];
        store_q.push_back(e);
        held_tok = (held_tok + tok) & BMASK;
        o.status = ST_ADDED;
      end
    end
    o.tokens = tok[TOK_W-1:0];
    o.ev_entries = step_n[CNT_W-1:0];
    o.ev_tokens = step_tok[BW-1:0];
    o.total = held_tok[BW-1:0];
    o.count = CNT_W'(store_q.size());
    o.remaining = BW'((budget_r > held_tok) ? budget_r - held_tok : 0);
    o.full = held_tok >= budget_r;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // outputs are sampled mid-cycle so flop updates have settled
  always @(negedge clk_i) begin
    outcome_t w;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, -1);
      end else begin
        w = pending_q.pop_front();
        check_field("status", status_o, w.status);
        check_field("message_tokens", message_tokens_o, w.tokens);
        check_field("evicted_entries", evicted_entries_o, w.ev_entries);
        check_field("evicted_tokens", evicted_tokens_o, w.ev_tokens);
        check_field("store_tokens", store_tokens_o, w.total);
        check_field("entry_count", entry_count_o, w.count);
        check_field("remaining_tokens", remaining_tokens_o, w.remaining);
        check_field("is_full", is_full_o, w.full);
      end
    end
  end

  // called at a rising edge; returns at the edge that took the request, or after a random idle gap with start_i low
  task automatic send_request(logic op, logic [1:0] prio, logic [BYTES_W-1:0] len);
    start_i <= 1'b1;
    opcode_i <= op;
    priority_level_i <= prio;
    byte_length_i <= len;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_q.push_back(predict_store(op, prio, len));
    if (!quiet && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(int unsigned budget, int unsigned bpt, bit auto_on, bit mode);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BUDGET;   cfg_wdata_i <= CFG_W'(budget); @(posedge clk_i);
    cfg_idx_i <= REG_BPT;      cfg_wdata_i <= CFG_W'(bpt);    @(posedge clk_i);
    cfg_idx_i <= REG_AUTO;     cfg_wdata_i <= CFG_W'(auto_on); @(posedge clk_i);
    cfg_idx_i <= REG_COMPMODE; cfg_wdata_i <= CFG_W'(mode);   @(posedge clk_i);
    cfg_we_i <= 1'b0;
    budget_r = budget & BMASK;
    bpt_r = bpt & 8'hFF;
    auto_r = auto_on;
    mode_r = mode;
  endtask

  task automatic random_requests(int unsigned n);
    int unsigned cap;
    logic [BYTES_W-1:0] len;
    cap = (bpt_r == 0) ? 255 : budget_r * bpt_r / 3;
    if (cap > 65535) cap = 65535;
    if (cap < 8) cap = 8;
    repeat (n) begin
      if ($urandom_range(99) < 70) len = BYTES_W'($urandom_range(0, cap));
      else len = BYTES_W'($urandom_range(0, 65535));
      send_request(($urandom_range(99) < 3) ? OP_CLEAR : OP_ADD,
                   2'($urandom_range(0, 3)), len);
    end
  endtask

  task automatic test_directed();
    send_request(OP_CLEAR, 2'd0, '0);            // clear while empty
    send_request(OP_ADD, 2'd0, '0);
    send_request(OP_ADD, 2'd3, 16'hFFFF);        // larger than budget
    send_request(OP_ADD, 2'd1, 16'd16384);       // exactly the budget
    for (int p = 0; p < 4; p++) send_request(OP_ADD, p[1:0], 16'd4001);
    send_request(OP_ADD, 2'd2, 16'd2);
    send_request(OP_CLEAR, 2'd3, 16'hFFFF);
  endtask

  task automatic test_tiers();
    // critical survives tiered removal, then forced eviction takes it
    program_regs(100, 1, 1, 1);
    send_request(OP_ADD, 2'd3, 16'd30);
    send_request(OP_ADD, 2'd2, 16'd20);
    send_request(OP_ADD, 2'd0, 16'd20);
    send_request(OP_ADD, 2'd1, 16'd20);
    send_request(OP_ADD, 2'd3, 16'd35);
    send_request(OP_ADD, 2'd3, 16'd80);
    program_regs(100, 1, 0, 1);                  // gate closed by auto
    random_requests(8);
    program_regs(100, 1, 1, 0);                  // gate closed by mode
    random_requests(8);
  endtask

  task automatic test_zero_divisor();
    program_regs(50, 0, 1, 1);
    send_request(OP_ADD, 2'd1, 16'hFFFF);
    random_requests(70);                          // zero-token requests, with random clears among them
  endtask

  task automatic test_full_store();
    program_regs(BMASK, 255, 1, 1);
    repeat (70) send_request(OP_ADD, 2'($urandom_range(0, 3)),
                             BYTES_W'($urandom_range(1, 255)));
    send_request(OP_ADD, 2'd3, 16'hFFFF);
  endtask

  task automatic test_budget_lowered();
    program_regs(5000, 1, 1, 1);
    repeat (6) send_request(OP_ADD, 2'($urandom_range(0, 3)),
                            BYTES_W'($urandom_range(500, 800)));
    program_regs(1000, 1, 1, 1);
    send_request(OP_ADD, 2'd0, 16'd0);           // remaining still shows the old budget's value until this
    send_request(OP_ADD, 2'd3, 16'd300);
  endtask

  task automatic test_random();
    program_regs(300, 4, 1, 1);   random_requests(30);
    quiet = 1'b1;
    program_regs(1, 1, 1, 1);     random_requests(25);
    quiet = 1'b0;
    program_regs(BMASK, 1, 1, 1); random_requests(30);
    program_regs(600, 1, 0, 1);   random_requests(30);
    program_regs(600, 2, 1, 0);   random_requests(30);
    program_regs(2000, 255, 1, 1); random_requests(30);
    program_regs(4096, 4, 1, 1);  random_requests(50);
    program_regs(150, 3, 0, 0);   random_requests(40);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tiers();
    test_zero_divisor();
    test_full_store();
    test_budget_lowered();
    test_random();
    wait_drain();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_priority_token_budget_evictor: done, clean");
    end else begin
      $display("tb_priority_token_budget_evictor: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
